/* hdl/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
// Package for the HSV to RGB converter: pipeline depth, sector codes,
// stage payload types and the reciprocal constants for the rounding divides.
// No dependencies.
package hsv2rgb_pkg;

   localparam int unsigned NumStages = 8;

   localparam int unsigned HueWidth = 9;
   localparam int unsigned PctWidth = 7;
   localparam int unsigned ChanWidth = 8;

   localparam logic [HueWidth-1:0] HueWrap = 9'd360;
   localparam logic [PctWidth-1:0] PctWrap = 7'd101;
   localparam logic [PctWidth-1:0] PctFull = 7'd100;

   // Rounded division by constant: floor((n + d/2) / d) = (n' * M) >> k
   localparam longint unsigned HiDiv = 100;
   localparam longint unsigned LoDiv = 10000;
   localparam longint unsigned MidDiv = 600000;
   localparam int unsigned HiShift = 22;
   localparam int unsigned LoShift = 36;
   localparam int unsigned MidShift = 48;
   localparam int unsigned HiNumWidth = 15;
   localparam int unsigned LoNumWidth = 22;
   localparam int unsigned MidNumWidth = 28;
   localparam int unsigned HiRecipWidth = 16;
   localparam int unsigned LoRecipWidth = 23;
   localparam int unsigned MidRecipWidth = 29;
   localparam logic [HiRecipWidth-1:0] HiRecip =
      HiRecipWidth'(((64'd1 << HiShift) + HiDiv - 64'd1) / HiDiv);
   localparam logic [LoRecipWidth-1:0] LoRecip =
      LoRecipWidth'(((64'd1 << LoShift) + LoDiv - 64'd1) / LoDiv);
   localparam logic [MidRecipWidth-1:0] MidRecip =
      MidRecipWidth'(((64'd1 << MidShift) + MidDiv - 64'd1) / MidDiv);

   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type          sector;
      logic [5:0]          frac;
      logic [PctWidth-1:0] sat;
      logic [PctWidth-1:0] val;
   } split_type;

   typedef struct packed {
      sector_type             sector;
      logic [HiNumWidth-1:0]  num_hi;
      logic [LoNumWidth-1:0]  num_lo;
      logic [MidNumWidth-1:0] num_mid;
   } num_type;

   function automatic logic sector_rising(input sector_type sector);
      return (sector == SEC_RY) || (sector == SEC_GC) || (sector == SEC_BM);
   endfunction

endpackage

/* hdl/hsv2rgb_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the HSV to RGB converter.
// Depends on hsv2rgb_pkg for field widths.
interface hsv2rgb_req_if
   import hsv2rgb_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [HueWidth-1:0] hue;
   logic [PctWidth-1:0] saturation;
   logic [PctWidth-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

interface hsv2rgb_rsp_if
   import hsv2rgb_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] red;
   logic [ChanWidth-1:0] green;
   logic [ChanWidth-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/hsv_to_rgb_converter_core.sv */
`timescale 1ns / 1ps
// HSV to RGB converter, top level.
// Depends on hsv2rgb_pkg, hsv2rgb_if and the hsv2rgb_* pipeline modules.
//
// Usage:
//   req_chan (sink) takes one pixel per request: hue in degrees, saturation
//   and brightness in percent. Hue wraps modulo 360, percents modulo 101.
//   rsp_chan (source) returns red, green and blue, 8 bits each, rounded to
//   nearest with ties up, one response per request, in request order.
//   Throughput is one pixel per clock while rsp_chan is ready. The 8
//   register stages are wrap, sector split, products, interpolation term,
//   value product, numerator, reciprocal multiply and channel ordering;
//   the reciprocal multiply stage sets the clock.
//   Each stage carries its own valid bit. When rsp_chan stalls, full stages
//   hold and empty stages ahead of the stall still fill, so requests are
//   taken until the pipeline is full; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline; data registers are not cleared.
module hsv_to_rgb_converter_core
   import hsv2rgb_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   hsv2rgb_req_if.sink   req_chan,
   hsv2rgb_rsp_if.source rsp_chan
   );

   logic [NumStages-1:0] stage_en;
   split_type            split;
   num_type              num;

   hsv2rgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .out_ready (rsp_chan.ready),
      .stage_en  (stage_en),
      .out_valid (rsp_chan.valid)
   );

   assign req_chan.ready = stage_en[0];

   hsv2rgb_reduce u_reduce (
      .clock      (clock),
      .stage_en   (stage_en[1:0]),
      .hue        (req_chan.hue),
      .saturation (req_chan.saturation),
      .brightness (req_chan.brightness),
      .split      (split)
   );

   hsv2rgb_scale u_scale (
      .clock    (clock),
      .stage_en (stage_en[5:2]),
      .split    (split),
      .num      (num)
   );

   hsv2rgb_round u_round (
      .clock    (clock),
      .stage_en (stage_en[7:6]),
      .num      (num),
      .red      (rsp_chan.red),
      .green    (rsp_chan.green),
      .blue     (rsp_chan.blue)
   );

endmodule

/* hdl/hsv2rgb_ctrl.sv */
`timescale 1ns / 1ps
// Pipeline control: per-stage valid bits and load enables with bubble collapse.
// Depends on hsv2rgb_pkg.
module hsv2rgb_ctrl
   import hsv2rgb_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 out_ready,
   output logic [NumStages-1:0] stage_en,
   output logic                 out_valid
   );

   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;

   always_comb begin
      stage_en[NumStages-1] = !vld_ff[NumStages-1] || out_ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      vld_in[0] = stage_en[0] ? in_valid : vld_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         if (stage_en[i]) begin
            vld_in[i] = vld_ff[i-1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[NumStages-1];

endmodule

/* hdl/hsv2rgb_reduce.sv */
`timescale 1ns / 1ps
// Stages 1-2: wrap hue and percents, split hue into sector and fraction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_reduce
   import hsv2rgb_pkg::*;
   (
   input  logic                clock,
   input  logic [1:0]          stage_en,
   input  logic [HueWidth-1:0] hue,
   input  logic [PctWidth-1:0] saturation,
   input  logic [PctWidth-1:0] brightness,
   output split_type           split
   );

   logic [HueWidth-1:0] hue_ff, hue_in;
   logic [PctWidth-1:0] sat_ff, sat_in;
   logic [PctWidth-1:0] val_ff, val_in;
   split_type           split_ff, split_in;
   logic [HueWidth-1:0] base;

   always_comb begin
      hue_in = (hue >= HueWrap) ? hue - HueWrap : hue;
      sat_in = (saturation >= PctWrap) ? saturation - PctWrap : saturation;
      val_in = (brightness >= PctWrap) ? brightness - PctWrap : brightness;
   end

   always_comb begin
      if (hue_ff >= 9'd300) begin
         split_in.sector = SEC_MR;
         base = 9'd300;
      end else if (hue_ff >= 9'd240) begin
         split_in.sector = SEC_BM;
         base = 9'd240;
      end else if (hue_ff >= 9'd180) begin
         split_in.sector = SEC_CB;
         base = 9'd180;
      end else if (hue_ff >= 9'd120) begin
         split_in.sector = SEC_GC;
         base = 9'd120;
      end else if (hue_ff >= 9'd60) begin
         split_in.sector = SEC_YG;
         base = 9'd60;
      end else begin
         split_in.sector = SEC_RY;
         base = 9'd0;
      end
      split_in.frac = 6'(hue_ff - base);
      split_in.sat = sat_ff;
      split_in.val = val_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= val_in;
      end
      if (stage_en[1]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

/* hdl/hsv2rgb_scale.sv */
`timescale 1ns / 1ps
// Stages 3-6: build the rounded-division numerators for max, min and mid.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale
   import hsv2rgb_pkg::*;
   (
   input  logic       clock,
   input  logic [3:0] stage_en,
   input  split_type  split,
   output num_type    num
   );

   // stage 3
   sector_type            sec3_ff;
   logic [PctWidth-1:0]   sat3_ff, val3_ff;
   logic [12:0]           fs3_ff, fs3_in;
   logic [13:0]           vl3_ff, vl3_in;
   logic [HiNumWidth-1:0] nhi3_ff, nhi3_in;
   // stage 4
   sector_type            sec4_ff;
   logic [PctWidth-1:0]   val4_ff;
   logic [12:0]           t4_ff, t4_in;
   logic [LoNumWidth-1:0] nlo4_ff, nlo4_in;
   logic [HiNumWidth-1:0] nhi4_ff;
   logic [13:0]           sat60;
   // stage 5
   sector_type            sec5_ff;
   logic [19:0]           vt5_ff, vt5_in;
   logic [LoNumWidth-1:0] nlo5_ff;
   logic [HiNumWidth-1:0] nhi5_ff;
   // stage 6
   num_type               num6_ff, num6_in;

   always_comb begin
      fs3_in = 13'(split.frac) * 13'(split.sat);
      vl3_in = 14'(split.val) * 14'(PctFull - split.sat);
      nhi3_in = (HiNumWidth'(split.val) << 8) - HiNumWidth'(split.val)
                + HiNumWidth'(HiDiv / 2);
   end

   always_comb begin
      sat60 = (14'(sat3_ff) << 6) - (14'(sat3_ff) << 2);
      if (sector_rising(sec3_ff)) begin
         t4_in = 13'(14'd6000 - sat60 + 14'(fs3_ff));
      end else begin
         t4_in = 13'(14'd6000 - 14'(fs3_ff));
      end
      nlo4_in = (LoNumWidth'(vl3_ff) << 8) - LoNumWidth'(vl3_ff)
                + LoNumWidth'(LoDiv / 2);
   end

   always_comb begin
      vt5_in = 20'(val4_ff) * 20'(t4_ff);
   end

   always_comb begin
      num6_in.sector = sec5_ff;
      num6_in.num_hi = nhi5_ff;
      num6_in.num_lo = nlo5_ff;
      num6_in.num_mid = (MidNumWidth'(vt5_ff) << 8) - MidNumWidth'(vt5_ff)
                        + MidNumWidth'(MidDiv / 2);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sec3_ff <= split.sector;
         sat3_ff <= split.sat;
         val3_ff <= split.val;
         fs3_ff  <= fs3_in;
         vl3_ff  <= vl3_in;
         nhi3_ff <= nhi3_in;
      end
      if (stage_en[1]) begin
         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
         t4_ff   <= t4_in;
         nlo4_ff <= nlo4_in;
         nhi4_ff <= nhi3_ff;
      end
      if (stage_en[2]) begin
         sec5_ff <= sec4_ff;
         vt5_ff  <= vt5_in;
         nlo5_ff <= nlo4_ff;
         nhi5_ff <= nhi4_ff;
      end
      if (stage_en[3]) begin
         num6_ff <= num6_in;
      end
   end

   assign num = num6_ff;

endmodule

/* hdl/hsv2rgb_round.sv */
`timescale 1ns / 1ps
// Stages 7-8: divide by reciprocal multiply, then order channels by sector.
// Depends on hsv2rgb_pkg.
module hsv2rgb_round
   import hsv2rgb_pkg::*;
   (
   input  logic                  clock,
   input  logic [1:0]            stage_en,
   input  num_type               num,
   output logic [ChanWidth-1:0]  red,
   output logic [ChanWidth-1:0]  green,
   output logic [ChanWidth-1:0]  blue
   );

   localparam int unsigned HiProdWidth = HiNumWidth + HiRecipWidth;
   localparam int unsigned LoProdWidth = LoNumWidth + LoRecipWidth;
   localparam int unsigned MidProdWidth = MidNumWidth + MidRecipWidth;

   sector_type              sec7_ff;
   logic [HiProdWidth-1:0]  phi_ff, phi_in;
   logic [LoProdWidth-1:0]  plo_ff, plo_in;
   logic [MidProdWidth-1:0] pmid_ff, pmid_in;
   logic [ChanWidth-1:0]    hi, lo, mid;
   logic [ChanWidth-1:0]    red_ff, red_in;
   logic [ChanWidth-1:0]    green_ff, green_in;
   logic [ChanWidth-1:0]    blue_ff, blue_in;

   always_comb begin
      phi_in = HiProdWidth'(num.num_hi) * HiProdWidth'(HiRecip);
      plo_in = LoProdWidth'(num.num_lo) * LoProdWidth'(LoRecip);
      pmid_in = MidProdWidth'(num.num_mid) * MidProdWidth'(MidRecip);
   end

   always_comb begin
      hi = phi_ff[HiShift +: ChanWidth];
      lo = plo_ff[LoShift +: ChanWidth];
      mid = pmid_ff[MidShift +: ChanWidth];
      unique case (sec7_ff)
         SEC_RY: begin
            red_in = hi;  green_in = mid; blue_in = lo;
         end
         SEC_YG: begin
            red_in = mid; green_in = hi;  blue_in = lo;
         end
         SEC_GC: begin
            red_in = lo;  green_in = hi;  blue_in = mid;
         end
         SEC_CB: begin
            red_in = lo;  green_in = mid; blue_in = hi;
         end
         SEC_BM: begin
            red_in = mid; green_in = lo;  blue_in = hi;
         end
         default: begin
            red_in = hi;  green_in = lo;  blue_in = mid;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sec7_ff <= num.sector;
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         pmid_ff <= pmid_in;
      end
      if (stage_en[1]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red = red_ff;
   assign green = green_ff;
   assign blue = blue_ff;

endmodule
